[hw/rtl/spring_force_three_mode_unit_macros.svh]
// ----------------------------------------------------------------------------
// Spring force unit assertion macros
// Concurrent assertion helpers clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPRING_FORCE_THREE_MODE_UNIT_MACROS_SVH
`define SPRING_FORCE_THREE_MODE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFM_ASSERT_IMP(lbl, ante, cons, msg)
`define SFM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/sfm_pkg.sv]
// ----------------------------------------------------------------------------
// Spring force package
// Widths, register and mode codes and shared types.
// ----------------------------------------------------------------------------
package sfm_pkg;

  localparam int POS_W      = 32;
  localparam int SUM_W      = 66;
  localparam int RAD_W      = 68;
  localparam int D_W        = 34;
  localparam int REM_W      = 35;
  localparam int N_W        = 17;
  localparam int MAG_W      = 48;
  localparam int ISQ_STAGES = 34;
  localparam int DIV_STAGES = 17;

  typedef enum logic [1:0] {
    KIND_SPRING = 2'd0,
    KIND_ANCHOR = 2'd1,
    KIND_BUNGEE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_KIND  = 2'd0,
    REG_STIFF = 2'd1,
    REG_REST  = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic       vld;
    logic       kill;
    logic       zero;
    logic       mneg;
    logic [2:0] neg;
  } ctl_t;

  typedef struct packed {
    logic [POS_W-1:0] fx;
    logic [POS_W-1:0] fy;
    logic [POS_W-1:0] fz;
    logic             applies;
  } res_t;

endpackage

[hw/rtl/sfm_isqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, floor root of a 66-bit radicand.
// ----------------------------------------------------------------------------
module sfm_isqrt import sfm_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] rad,
  output logic [D_W-1:0]   root
);

  logic [REM_W-1:0] rem_r  [ISQ_STAGES];
  logic [D_W-1:0]   root_r [ISQ_STAGES];
  logic [RAD_W-1:0] rad_r  [ISQ_STAGES];

  for (genvar j = 0; j < ISQ_STAGES; j++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [D_W-1:0]   root_in;
    logic [RAD_W-1:0] rad_in;
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {2'b00, rad};
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign rad_in  = rad_r[j-1];
    end

    assign r2    = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? REM_W'(r2 - trial) : REM_W'(r2);
        root_r[j] <= {root_in[D_W-2:0], ge};
        rad_r[j]  <= {rad_in[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[ISQ_STAGES-1];

endmodule

[hw/rtl/sfm_div.sv]
// ----------------------------------------------------------------------------
// Pipelined unit-vector divider
// Three lanes of restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sfm_div import sfm_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [D_W-1:0]        dvsr,
  input  logic [2:0][POS_W-1:0] dvnd,
  output logic [2:0][N_W-1:0]   quo
);

  logic [D_W-1:0] d_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_dstage
    logic [D_W-1:0] d_in;
    if (j == 0) begin : g_first
      assign d_in = dvsr;
    end else begin : g_next
      assign d_in = d_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[j] <= d_in;
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [REM_W-1:0] rem_r [DIV_STAGES];
    logic [N_W-1:0]   q_r   [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      logic [REM_W-1:0] rem_in;
      logic [N_W-1:0]   q_in;
      logic [D_W-1:0]   d_in;
      logic             ge;

      if (j == 0) begin : g_first
        assign rem_in = {3'b000, dvnd[l]};
        assign q_in   = '0;
        assign d_in   = dvsr;
      end else begin : g_next
        assign rem_in = {rem_r[j-1][REM_W-2:0], 1'b0};
        assign q_in   = q_r[j-1];
        assign d_in   = d_r[j-1];
      end

      assign ge = (rem_in >= {1'b0, d_in});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? (rem_in - {1'b0, d_in}) : rem_in;
          q_r[j]   <= {q_in[N_W-2:0], ge};
        end
      end
    end

    assign quo[l] = q_r[DIV_STAGES-1];
  end

endmodule

[hw/rtl/spring_force_three_mode_unit.sv]
// ----------------------------------------------------------------------------
// Three-mode spring force unit
// Hooke spring, anchored spring and bungee force in Q16.16, one item a cycle while in_stall is low.
// ----------------------------------------------------------------------------
// One item enters every cycle while in_stall is low. Three stages form the
// separation and its squared length, 34 stages take the square root one bit
// each, three stages form the magnitude k*|L-d|, 17 stages divide out the unit
// vector one bit each, two stages scale it and the output register saturates.
// A two-entry output buffer lets the pipe keep taking items while one result
// waits; in_stall rises only when both are full. The user must write
// configuration only while the unit is empty; the unit does not enforce this.
module spring_force_three_mode_unit import sfm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [POS_W-1:0] in_pos_x,
  input  logic [POS_W-1:0] in_pos_y,
  input  logic [POS_W-1:0] in_pos_z,
  input  logic [POS_W-1:0] in_ref_x,
  input  logic [POS_W-1:0] in_ref_y,
  input  logic [POS_W-1:0] in_ref_z,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [POS_W-1:0] out_force_x,
  output logic [POS_W-1:0] out_force_y,
  output logic [POS_W-1:0] out_force_z,
  output logic             out_force_applies
);

`include "spring_force_three_mode_unit_macros.svh"

  kind_t       kind_r;
  logic [31:0] stiff_r;
  logic [31:0] rest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_SPRING;
      stiff_r <= 32'd65536;
      rest_r  <= 32'd65536;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KIND:  kind_r  <= kind_t'(cfg_data[1:0]);
        REG_STIFF: stiff_r <= cfg_data;
        REG_REST:  rest_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_vld_r;
  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // separation
  logic [2:0][POS_W-1:0] pos_w, ref_w;
  logic [2:0][POS_W:0]   diff_w;
  assign pos_w = {in_pos_z, in_pos_y, in_pos_x};
  assign ref_w = {in_ref_z, in_ref_y, in_ref_x};

  logic                  vld1_r, vld2_r, vld3_r;
  logic [2:0]            neg1_r, neg2_r, neg3_r;
  logic [2:0][POS_W-1:0] av1_r, av2_r, av3_r;
  logic [2:0][63:0]      sq2_r;
  logic [SUM_W-1:0]      sum3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_w[i] = {pos_w[i][POS_W-1], pos_w[i]} - {ref_w[i][POS_W-1], ref_w[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_r[i] <= diff_w[i][POS_W];
        av1_r[i]  <= diff_w[i][POS_W] ? POS_W'(-diff_w[i]) : diff_w[i][POS_W-1:0];
        sq2_r[i]  <= av1_r[i] * av1_r[i];
      end
      neg2_r <= neg1_r;
      av2_r  <= av1_r;
      neg3_r <= neg2_r;
      av3_r  <= av2_r;
      sum3_r <= {2'b00, sq2_r[0]} + {2'b00, sq2_r[1]} + {2'b00, sq2_r[2]};
    end
  end

  // length
  logic [D_W-1:0] d_w;

  sfm_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum3_r),
    .root (d_w)
  );

  logic                  vq_r   [ISQ_STAGES];
  logic [2:0]            negq_r [ISQ_STAGES];
  logic [2:0][POS_W-1:0] avq_r  [ISQ_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < ISQ_STAGES; j++) begin
        vq_r[j] <= 1'b0;
      end
    end else if (en) begin
      vq_r[0] <= vld3_r;
      for (int j = 1; j < ISQ_STAGES; j++) begin
        vq_r[j] <= vq_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negq_r[0] <= neg3_r;
      avq_r[0]  <= av3_r;
      for (int j = 1; j < ISQ_STAGES; j++) begin
        negq_r[j] <= negq_r[j-1];
        avq_r[j]  <= avq_r[j-1];
      end
    end
  end

  // mode and magnitude
  logic [35:0] ld_w;
  ctl_t        ctl_w;
  assign ld_w = {4'b0000, rest_r} - {2'b00, d_w};

  always_comb begin
    ctl_w.vld  = vq_r[ISQ_STAGES-1];
    ctl_w.kill = (kind_r == KIND_NONE) ||
                 ((kind_r == KIND_BUNGEE) && (d_w <= {2'b00, rest_r}));
    ctl_w.zero = (d_w == '0);
    ctl_w.mneg = (kind_r == KIND_SPRING) ? 1'b1 : ld_w[35];
    ctl_w.neg  = negq_r[ISQ_STAGES-1];
  end

  ctl_t                  ctla_r, ctlm1_r, ctlm2_r;
  logic [REM_W-1:0]      a_r;
  logic [D_W-1:0]        da_r, dm1_r, dm2_r;
  logic [2:0][POS_W-1:0] ava_r, avm1_r, avm2_r;
  logic [63:0]           plo_r;
  logic [34:0]           phi_r;
  logic [MAG_W-1:0]      mag_r;
  logic [66:0]           prod_w;

  assign prod_w = {3'b000, plo_r} + {phi_r, 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctla_r.vld  <= 1'b0;
      ctlm1_r.vld <= 1'b0;
      ctlm2_r.vld <= 1'b0;
    end else if (en) begin
      ctla_r.vld  <= ctl_w.vld;
      ctlm1_r.vld <= ctla_r.vld;
      ctlm2_r.vld <= ctlm1_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctla_r.kill <= ctl_w.kill;
      ctla_r.zero <= ctl_w.zero;
      ctla_r.mneg <= ctl_w.mneg;
      ctla_r.neg  <= ctl_w.neg;
      a_r         <= ld_w[35] ? REM_W'(-ld_w) : ld_w[REM_W-1:0];
      da_r        <= d_w;
      ava_r       <= avq_r[ISQ_STAGES-1];
      ctlm1_r.kill <= ctla_r.kill;
      ctlm1_r.zero <= ctla_r.zero;
      ctlm1_r.mneg <= ctla_r.mneg;
      ctlm1_r.neg  <= ctla_r.neg;
      plo_r  <= stiff_r * a_r[31:0];
      phi_r  <= stiff_r * a_r[REM_W-1:32];
      dm1_r  <= da_r;
      avm1_r <= ava_r;
      ctlm2_r.kill <= ctlm1_r.kill;
      ctlm2_r.zero <= ctlm1_r.zero;
      ctlm2_r.mneg <= ctlm1_r.mneg;
      ctlm2_r.neg  <= ctlm1_r.neg;
      mag_r  <= (prod_w[66:63] != 4'd0) ? {1'b1, {(MAG_W-1){1'b0}}}
                                        : {1'b0, prod_w[62:16]};
      dm2_r  <= dm1_r;
      avm2_r <= avm1_r;
    end
  end

  // unit vector
  logic [2:0][N_W-1:0] n_w;

  sfm_div u_div (
    .clk  (clk),
    .en   (en),
    .dvsr (dm2_r),
    .dvnd (avm2_r),
    .quo  (n_w)
  );

  ctl_t             ctlv_r [DIV_STAGES];
  logic [MAG_W-1:0] magv_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        ctlv_r[j].vld <= 1'b0;
      end
    end else if (en) begin
      ctlv_r[0].vld <= ctlm2_r.vld;
      for (int j = 1; j < DIV_STAGES; j++) begin
        ctlv_r[j].vld <= ctlv_r[j-1].vld;
      end
    end
    if (en) begin
      ctlv_r[0].kill <= ctlm2_r.kill;
      ctlv_r[0].zero <= ctlm2_r.zero;
      ctlv_r[0].mneg <= ctlm2_r.mneg;
      ctlv_r[0].neg  <= ctlm2_r.neg;
      magv_r[0]      <= mag_r;
      for (int j = 1; j < DIV_STAGES; j++) begin
        ctlv_r[j].kill <= ctlv_r[j-1].kill;
        ctlv_r[j].zero <= ctlv_r[j-1].zero;
        ctlv_r[j].mneg <= ctlv_r[j-1].mneg;
        ctlv_r[j].neg  <= ctlv_r[j-1].neg;
        magv_r[j]      <= magv_r[j-1];
      end
    end
  end

  // scale
  ctl_t             ctlf1_r, ctlf2_r;
  logic [2:0][48:0] pl_r;
  logic [2:0][32:0] ph_r;
  logic [2:0][48:0] f_r;
  logic [2:0][64:0] full_w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full_w[i] = {16'd0, pl_r[i]} + {ph_r[i], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctlf1_r.vld <= 1'b0;
      ctlf2_r.vld <= 1'b0;
    end else if (en) begin
      ctlf1_r.vld <= ctlv_r[DIV_STAGES-1].vld;
      ctlf2_r.vld <= ctlf1_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctlf1_r.kill <= ctlv_r[DIV_STAGES-1].kill;
      ctlf1_r.zero <= ctlv_r[DIV_STAGES-1].zero;
      ctlf1_r.mneg <= ctlv_r[DIV_STAGES-1].mneg;
      ctlf1_r.neg  <= ctlv_r[DIV_STAGES-1].neg;
      ctlf2_r.kill <= ctlf1_r.kill;
      ctlf2_r.zero <= ctlf1_r.zero;
      ctlf2_r.mneg <= ctlf1_r.mneg;
      ctlf2_r.neg  <= ctlf1_r.neg;
      for (int i = 0; i < 3; i++) begin
        pl_r[i] <= magv_r[DIV_STAGES-1][31:0] * n_w[i];
        ph_r[i] <= magv_r[DIV_STAGES-1][MAG_W-1:32] * n_w[i];
        f_r[i]  <= (ctlf1_r.kill || ctlf1_r.zero) ? 49'd0 : full_w[i][64:16];
      end
    end
  end

  // saturate
  logic [2:0][POS_W-1:0] sat_w;
  res_t                  pipe_res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (f_r[i] == '0) begin
        sat_w[i] = '0;
      end else if (ctlf2_r.mneg != ctlf2_r.neg[i]) begin
        sat_w[i] = (f_r[i][48:31] != '0) ? 32'h8000_0000 : POS_W'(-f_r[i][31:0]);
      end else begin
        sat_w[i] = (f_r[i][48:31] != '0) ? 32'h7FFF_FFFF : f_r[i][31:0];
      end
    end
    pipe_res.fx      = sat_w[0];
    pipe_res.fy      = sat_w[1];
    pipe_res.fz      = sat_w[2];
    pipe_res.applies = !ctlf2_r.kill;
  end

  // output register and skid entry
  logic out_vld_r;
  res_t out_r, skid_r;
  logic load_out, load_skid;

  assign load_out  = !out_vld_r || !out_stall;
  assign load_skid = !load_out && ctlf2_r.vld && !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r  <= skid_vld_r || ctlf2_r.vld;
      skid_vld_r <= 1'b0;
    end else if (load_skid) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= skid_vld_r ? skid_r : pipe_res;
    end
    if (load_skid) begin
      skid_r <= pipe_res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_force_x       = out_r.fx;
  assign out_force_y       = out_r.fy;
  assign out_force_z       = out_r.fz;
  assign out_force_applies = out_r.applies;

  `SFM_ASSERT_IMP(a_slack_zero, out_valid && !out_force_applies,
    (out_force_x == '0) && (out_force_y == '0) && (out_force_z == '0),
    "force given with no force applied")
  `SFM_ASSERT_IMP(a_skid_behind_out, skid_vld_r, out_vld_r,
    "skid entry held while output empty")
  `SFM_ASSERT_NXT(a_skid_fill, !skid_vld_r && !in_stall && out_valid && out_stall
    && ctlf2_r.vld, skid_vld_r, "result lost while output stalled")

endmodule
